FILE: sv/tpbb_pkg.sv
// package: types and constants for the three-pass box blur
package tpbb_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefMaxRadius = 15;

  localparam int unsigned SizeW   = 9;
  localparam int unsigned RadW    = 4;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 9;

  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_DONE   = 2'd1,
    ST_READ   = 2'd2
  } status_t;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RAD0   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RAD1   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RAD2   = 3'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [IndexW-1:0] pixel_index;
    logic [ChanW-1:0]  in_red;
    logic [ChanW-1:0]  in_green;
    logic [ChanW-1:0]  in_blue;
    logic [ChanW-1:0]  in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } out_item_t;

endpackage

FILE: sv/tpbb_ram.sv
// generic single-port ram with registered read
module tpbb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: sv/tpbb_scale.sv
// scales one channel sum by a q0.16 reciprocal, rounds and clips to 8 bits
module tpbb_scale #(
  parameter int unsigned SUM_W = 13
) (
  input  logic [SUM_W-1:0] sum,
  input  logic [15:0]      recip,
  output logic [7:0]       chan
);
  logic [SUM_W+16:0] prod;
  logic [SUM_W:0]    v;

  assign prod = ({1'b0, sum, 16'd0} >> 16) * (SUM_W + 17)'(recip) + (SUM_W + 17)'(32768);
  assign v    = prod[SUM_W+16:16];
  assign chan = (v > (SUM_W + 1)'(255)) ? 8'hFF : v[7:0];
endmodule

FILE: sv/three_pass_box_blur.sv
// top level: rgba frame store with a three-pass box blur sequencer
// Usage: configuration writes go through cfg_valid/cfg_ready with cfg_index
// (0 width, 1 height, 2..4 radii) and cfg_data; take them only when idle.
// Items on in_valid/in_ready carry an action: store a pixel, run the blur
// or read a pixel. Each item gives one result on out_valid/out_ready.
// A store result is presented the cycle after acceptance; a read result
// first passes through S_RDWAIT, where the frame store data is registered.
// A run walks the frame six times (three passes, each horizontal then
// vertical). Per line it clears the sums in S_LINE and makes the 2r+1
// window reads through S_PRIME and S_PRIME_ACC. Then per position it writes
// in S_EMIT and, after the first position, makes the add and remove reads
// in S_ADD, S_SUB and S_SUB_ACC. Each store has a single memory port.
// in_ready is low from acceptance until the result is taken, so a stall
// on out_ready holds the result and blocks further items.
// Reset (rst, synchronous) returns the registers to width 64, height 64,
// radii 1 and clears control; the stores hold whatever they held.
module three_pass_box_blur #(
  parameter int unsigned MAX_WIDTH  = tpbb_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = tpbb_pkg::DefMaxHeight,
  parameter int unsigned MAX_RADIUS = tpbb_pkg::DefMaxRadius
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tpbb_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [tpbb_pkg::CfgDatW-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tpbb_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tpbb_pkg::out_item_t                   out_item
);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;
  localparam int unsigned SumW  = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int unsigned RadIdxW = $clog2(MAX_RADIUS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_LINE, S_PRIME, S_PRIME_ACC,
    S_EMIT, S_ADD, S_SUB, S_SUB_ACC, S_RESP
  } state_t;

  state_t state;
  logic [8:0] frame_width, frame_height;
  logic [3:0] radius [3];

  logic [PW-1:0] w_eff, h_eff;
  logic [1:0]    pass;
  logic          vert;
  logic [PW-1:0] line_cnt, pos, lines, len;
  logic signed [PW+7:0] k;
  logic [6:0]    r_eff;
  logic [15:0]   recip;
  logic [15:0]   recip_tab [MAX_RADIUS+1];
  logic [SumW-1:0] sums [4];
  logic [AW+PW:0]  fetch_addr_full;
  logic [AW-1:0]   addr;
  logic            src_work;
  logic            f_we, w_we;
  logic [31:0]     f_wdata, w_wdata, f_rdata, w_rdata, src_data, blur_pix;
  logic [AW-1:0]   f_addr, w_addr;

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_ready  = (state == S_IDLE) && !out_valid;

  // q0.16 reciprocal of 2r+1, rounded, 65535 for r = 0
  genvar g;
  generate
    for (g = 0; g <= MAX_RADIUS; g++) begin : g_recip
      localparam int unsigned Quot = (131072 / (2 * g + 1) + 1) / 2;
      assign recip_tab[g] = (Quot > 65535) ? 16'hFFFF : 16'(Quot);
    end
  endgenerate

  // effective frame sizes
  always_comb begin
    w_eff = (frame_width == 9'd0) ? PW'(1) : PW'(frame_width);
    h_eff = (frame_height == 9'd0) ? PW'(1) : PW'(frame_height);
    if (32'(frame_width) > MAX_WIDTH)   w_eff = PW'(MAX_WIDTH);
    if (32'(frame_height) > MAX_HEIGHT) h_eff = PW'(MAX_HEIGHT);
    r_eff = (32'(radius[pass]) > MAX_RADIUS) ? 7'(MAX_RADIUS) : 7'(radius[pass]);
    recip = recip_tab[r_eff[RadIdxW-1:0]];
    lines = vert ? w_eff : h_eff;
    len   = vert ? h_eff : w_eff;
  end

  // clamped window position for the current fetch
  logic signed [PW+7:0] fpos;
  logic [PW-1:0] cpos;
  always_comb begin
    priority case (state)
      S_ADD:   fpos = $signed({8'd0, pos}) + $signed({{(PW+1){1'b0}}, r_eff});
      S_SUB:   fpos = $signed({8'd0, pos}) - $signed((PW+8)'(1))
                      - $signed({{(PW+1){1'b0}}, r_eff});
      default: fpos = k;
    endcase
    if (fpos < 0) cpos = '0;
    else if (fpos >= $signed({8'd0, len})) cpos = len - 1'b1;
    else cpos = fpos[PW-1:0];
  end

  logic [PW-1:0] apos;
  assign apos = (state == S_EMIT) ? pos : cpos;
  assign fetch_addr_full = vert
    ? (AW+PW+1)'(apos) * (AW+PW+1)'(w_eff) + (AW+PW+1)'(line_cnt)
    : (AW+PW+1)'(line_cnt) * (AW+PW+1)'(w_eff) + (AW+PW+1)'(apos);
  assign addr = fetch_addr_full[AW-1:0];

  assign src_work = vert;
  assign src_data = src_work ? w_rdata : f_rdata;

  genvar c;
  generate
    for (c = 0; c < 4; c++) begin : g_scale
      tpbb_scale #(.SUM_W(SumW)) u_scale (
        .sum(sums[c]), .recip(recip), .chan(blur_pix[8*c +: 8])
      );
    end
  endgenerate

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    f_we = 1'b0; w_we = 1'b0;
    f_addr = addr; w_addr = addr;
    f_wdata = blur_pix; w_wdata = blur_pix;
    if (state == S_IDLE) begin
      f_addr = AW'(in_item.pixel_index);
      f_wdata = {in_item.in_alpha, in_item.in_blue, in_item.in_green, in_item.in_red};
      f_we = in_fire && (in_item.action == tpbb_pkg::ACT_STORE)
             && (32'(in_item.pixel_index) < Depth);
    end else if (state == S_EMIT) begin
      if (vert) f_we = 1'b1; else w_we = 1'b1;
    end
  end

  tpbb_ram #(.WIDTH(tpbb_pkg::PixW), .DEPTH(Depth)) u_frame (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );
  tpbb_ram #(.WIDTH(tpbb_pkg::PixW), .DEPTH(Depth)) u_work (
    .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata)
  );

  logic rd_oob;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      frame_width <= 9'd64;
      frame_height <= 9'd64;
      radius[0] <= 4'd1; radius[1] <= 4'd1; radius[2] <= 4'd1;
      pass <= '0; vert <= 1'b0;
      for (int i = 0; i < 4; i++) sums[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tpbb_pkg::REG_WIDTH:  frame_width <= cfg_data;
          tpbb_pkg::REG_HEIGHT: frame_height <= cfg_data;
          tpbb_pkg::REG_RAD0:   radius[0] <= cfg_data[3:0];
          tpbb_pkg::REG_RAD1:   radius[1] <= cfg_data[3:0];
          tpbb_pkg::REG_RAD2:   radius[2] <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_fire) begin
          rd_oob <= 32'(in_item.pixel_index) >= Depth;
          unique case (in_item.action)
            tpbb_pkg::ACT_STORE, tpbb_pkg::ACT_NONE: begin
              out_item <= '{status: tpbb_pkg::ST_STORED, default: '0};
              out_valid <= 1'b1;
            end
            tpbb_pkg::ACT_READ: state <= S_RDWAIT;
            default: begin
              pass <= '0; vert <= 1'b0; line_cnt <= '0;
              state <= S_LINE;
            end
          endcase
        end
        // read data arrives the cycle after the address
        S_RDWAIT: begin
          out_item <= '{status:    tpbb_pkg::ST_READ,
                        out_red:   rd_oob ? 8'd0 : f_rdata[7:0],
                        out_green: rd_oob ? 8'd0 : f_rdata[15:8],
                        out_blue:  rd_oob ? 8'd0 : f_rdata[23:16],
                        out_alpha: rd_oob ? 8'd0 : f_rdata[31:24]};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_LINE: begin
          for (int i = 0; i < 4; i++) sums[i] <= '0;
          k <= -$signed({{(PW+1){1'b0}}, r_eff});
          pos <= '0;
          state <= S_PRIME;
        end
        // issue a window read, accumulate it in the cycle after
        S_PRIME: state <= S_PRIME_ACC;
        S_PRIME_ACC: begin
          for (int i = 0; i < 4; i++) sums[i] <= sums[i] + SumW'(src_data[8*i +: 8]);
          if (k == $signed({{(PW+1){1'b0}}, r_eff})) state <= S_EMIT;
          else begin
            k <= k + $signed((PW+8)'(1));
            state <= S_PRIME;
          end
        end
        S_EMIT: begin
          if (pos == len - 1'b1) begin
            if (line_cnt == lines - 1'b1) begin
              line_cnt <= '0;
              if (vert) begin
                vert <= 1'b0;
                if (pass == 2'd2) state <= S_RESP;
                else begin pass <= pass + 1'b1; state <= S_LINE; end
              end else begin
                vert <= 1'b1; state <= S_LINE;
              end
            end else begin
              line_cnt <= line_cnt + 1'b1;
              state <= S_LINE;
            end
          end else begin
            pos <= pos + 1'b1;
            state <= S_ADD;
          end
        end
        S_ADD: state <= S_SUB;
        S_SUB: begin
          for (int i = 0; i < 4; i++) sums[i] <= sums[i] + SumW'(src_data[8*i +: 8]);
          state <= S_SUB_ACC;
        end
        S_SUB_ACC: begin
          for (int i = 0; i < 4; i++) sums[i] <= sums[i] - SumW'(src_data[8*i +: 8]);
          state <= S_EMIT;
        end
        S_RESP: begin
          out_item <= '{status: tpbb_pkg::ST_DONE, default: '0};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
endmodule

FILE: test/tb_top.sv
// testbench for the three-pass box blur: scoreboard with a frame predictor and handshake drivers
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned HoldCycles = 400;

  class blur_scoreboard;
    bit [31:0]   frame_mem [StoreDepth];
    bit [31:0]   work_mem [StoreDepth];
    int unsigned width_reg = 64;
    int unsigned height_reg = 64;
    int unsigned radius_reg [3] = '{1, 1, 1};
    tpbb_pkg::out_item_t pending_q [$];
    int unsigned errors;

    task flag(input string what, input int unsigned got, input int unsigned want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
    endtask

    function void write_reg(input logic [tpbb_pkg::CfgIdxW-1:0] idx, input int unsigned val);
      case (idx)
        tpbb_pkg::REG_WIDTH:  width_reg = val & 9'h1FF;
        tpbb_pkg::REG_HEIGHT: height_reg = val & 9'h1FF;
        tpbb_pkg::REG_RAD0:   radius_reg[0] = val & 4'hF;
        tpbb_pkg::REG_RAD1:   radius_reg[1] = val & 4'hF;
        tpbb_pkg::REG_RAD2:   radius_reg[2] = val & 4'hF;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_pos(input int p, input int unsigned len);
      if (p < 0) return 0;
      if (p >= int'(len)) return len - 1;
      return p;
    endfunction

    // one sliding-window half pass; horizontal goes frame to work, vertical back
    function void blur_half(input bit horiz, input int unsigned w, input int unsigned h,
                            input int unsigned r);
      int unsigned lines, len, recip, q, a, scaled;
      int unsigned sums [4];
      bit [31:0] px, o;
      lines = horiz ? h : w;
      len = horiz ? w : h;
      q = (131072 / (2 * r + 1) + 1) / 2;
      recip = (q > 65535) ? 65535 : q;
      for (int unsigned ln = 0; ln < lines; ln++) begin
        sums = '{0, 0, 0, 0};
        for (int k = -int'(r); k <= int'(r); k++) begin
          a = horiz ? ln * w + clamp_pos(k, len) : clamp_pos(k, len) * w + ln;
          px = horiz ? frame_mem[a] : work_mem[a];
          for (int c = 0; c < 4; c++) sums[c] += px[8*c +: 8];
        end
        for (int unsigned pos = 0; pos < len; pos++) begin
          if (pos > 0) begin
            a = clamp_pos(int'(pos) + int'(r), len);
            a = horiz ? ln * w + a : a * w + ln;
            px = horiz ? frame_mem[a] : work_mem[a];
            for (int c = 0; c < 4; c++) sums[c] += px[8*c +: 8];
            a = clamp_pos(int'(pos) - 1 - int'(r), len);
            a = horiz ? ln * w + a : a * w + ln;
            px = horiz ? frame_mem[a] : work_mem[a];
            for (int c = 0; c < 4; c++) sums[c] -= px[8*c +: 8];
          end
          for (int c = 0; c < 4; c++) begin
            scaled = (longint'(sums[c]) * recip + 32768) >> 16;
            o[8*c +: 8] = (scaled > 255) ? 8'd255 : scaled[7:0];
          end
          a = horiz ? ln * w + pos : pos * w + ln;
          if (horiz) work_mem[a] = o;
          else frame_mem[a] = o;
        end
      end
    endfunction

    function void note_input(input tpbb_pkg::in_item_t it);
      tpbb_pkg::out_item_t exp_item;
      int unsigned w, h, r;
      bit [31:0] px;
      exp_item = '0;
      case (tpbb_pkg::action_t'(it.action))
        tpbb_pkg::ACT_STORE: begin
          frame_mem[it.pixel_index] = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
          exp_item.status = tpbb_pkg::ST_STORED;
        end
        tpbb_pkg::ACT_RUN: begin
          w = (width_reg == 0) ? 1 : (width_reg > tpbb_pkg::DefMaxWidth
                                      ? tpbb_pkg::DefMaxWidth : width_reg);
          h = (height_reg == 0) ? 1 : (height_reg > tpbb_pkg::DefMaxHeight
                                       ? tpbb_pkg::DefMaxHeight : height_reg);
          for (int p = 0; p < 3; p++) begin
            r = (radius_reg[p] > tpbb_pkg::DefMaxRadius) ? tpbb_pkg::DefMaxRadius
                                                         : radius_reg[p];
            blur_half(1'b1, w, h, r);
            blur_half(1'b0, w, h, r);
          end
          exp_item.status = tpbb_pkg::ST_DONE;
        end
        tpbb_pkg::ACT_READ: begin
          px = frame_mem[it.pixel_index];
          exp_item.status = tpbb_pkg::ST_READ;
          {exp_item.out_alpha, exp_item.out_blue, exp_item.out_green, exp_item.out_red} = px;
        end
        default: exp_item.status = tpbb_pkg::ST_STORED;
      endcase
      pending_q = {pending_q, exp_item};
    endfunction

    task check_result(input tpbb_pkg::out_item_t got);
      tpbb_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        flag("unexpected item, status", got.status, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) flag("status", got.status, want.status);
      if (got.out_red !== want.out_red) flag("red", got.out_red, want.out_red);
      if (got.out_green !== want.out_green) flag("green", got.out_green, want.out_green);
      if (got.out_blue !== want.out_blue) flag("blue", got.out_blue, want.out_blue);
      if (got.out_alpha !== want.out_alpha) flag("alpha", got.out_alpha, want.out_alpha);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tpbb_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [tpbb_pkg::CfgDatW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  tpbb_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tpbb_pkg::out_item_t out_item;

  blur_scoreboard sb = new();
  int unsigned send_idle_pct, recv_idle_pct;
  bit hold_req;
  int unsigned cycles;
  int unsigned area;
  int unsigned extra_idx [$];

  three_pass_box_blur i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check, then pick ready for the next edge
  initial begin
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_item);
      if (held > 0) begin
        held--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        held = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task write_cfg(input logic [tpbb_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[tpbb_pkg::CfgDatW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task send_item(input tpbb_pkg::action_t act, input int unsigned idx, input bit [31:0] px);
    tpbb_pkg::in_item_t it;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    it.action = act;
    it.pixel_index = idx[tpbb_pkg::IndexW-1:0];
    {it.in_alpha, it.in_blue, it.in_green, it.in_red} = px;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task drain;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function int unsigned eff_size(input int unsigned v);
    v = v & 9'h1FF;
    return (v == 0) ? 1 : (v > tpbb_pkg::DefMaxWidth ? tpbb_pkg::DefMaxWidth : v);
  endfunction

  task pick_read(output int unsigned idx);
    if (extra_idx.size() != 0 && $urandom_range(3) == 0)
      idx = extra_idx[$urandom_range(extra_idx.size() - 1)];
    else
      idx = $urandom_range(area - 1);
  endtask

  initial begin
    int unsigned widths [6];
    int unsigned heights [6];
    int unsigned rad_a [6];
    int unsigned rad_b [6];
    int unsigned rad_c [6];
    int unsigned idx, sel, filled;
    widths = '{4, 0, 511, 1, 7, 13};
    heights = '{4, 5, 1, 300, 3, 9};
    rad_a = '{0, 15, 3, 15, 2, 5};
    rad_b = '{1, 0, 15, 7, 9, 1};
    rad_c = '{15, 2, 0, 1, 4, 11};
    filled = 0;
    send_idle_pct = 16;
    recv_idle_pct = 61;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 61;
        recv_idle_pct = 16;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_cfg(tpbb_pkg::REG_WIDTH, widths[ph]);
      write_cfg(tpbb_pkg::REG_HEIGHT, heights[ph]);
      write_cfg(tpbb_pkg::REG_RAD0, rad_a[ph]);
      write_cfg(tpbb_pkg::REG_RAD1, rad_b[ph]);
      write_cfg(tpbb_pkg::REG_RAD2, rad_c[ph]);
      area = eff_size(widths[ph]) * eff_size(heights[ph]);
      // every pixel of the frame in use gets written before any run
      for (int unsigned i = filled; i < area; i++) begin
        if (ph == 0) send_item(tpbb_pkg::ACT_STORE, i, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
        else send_item(tpbb_pkg::ACT_STORE, i, $urandom());
      end
      if (area > filled) filled = area;
      if (ph == 0) begin
        send_item(tpbb_pkg::ACT_STORE, 65535, 32'hFFFF_FFFF);
        extra_idx = {extra_idx, 65535};
        send_item(tpbb_pkg::ACT_READ, 65535, 32'h0);
        send_item(tpbb_pkg::ACT_READ, 0, 32'h0);
        send_item(tpbb_pkg::ACT_NONE, $urandom_range(65535), $urandom());
        send_item(tpbb_pkg::ACT_RUN, 0, 32'h0);
        for (int unsigned i = 0; i < area; i++) send_item(tpbb_pkg::ACT_READ, i, 32'h0);
      end
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 16; n++) begin
        sel = $urandom_range(99);
        if (sel < 35) begin
          send_item(tpbb_pkg::ACT_STORE, $urandom_range(area - 1), $urandom());
        end else if (sel < 45) begin
          idx = $urandom_range(65535);
          send_item(tpbb_pkg::ACT_STORE, idx, $urandom());
          if (idx >= area) extra_idx = {extra_idx, idx};
        end else if (sel < 85) begin
          pick_read(idx);
          send_item(tpbb_pkg::ACT_READ, idx, $urandom());
        end else if (sel < 90) begin
          send_item(tpbb_pkg::ACT_RUN, $urandom_range(65535), $urandom());
        end else begin
          send_item(tpbb_pkg::ACT_NONE, $urandom_range(65535), $urandom());
        end
      end
      send_item(tpbb_pkg::ACT_RUN, 0, 32'h0);
      for (int n = 0; n < 8; n++) begin
        pick_read(idx);
        send_item(tpbb_pkg::ACT_READ, idx, 32'h0);
      end
      drain();
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tpbb_pkg.sv
sv/tpbb_ram.sv
sv/tpbb_scale.sv
sv/three_pass_box_blur.sv
test/tb_top.sv
